### rtl/utrx_pkg.sv
// Package for the gene-overlap UTR extension block.
// Holds the sizes, command, kind and status codes, and the shared structs.
// No dependencies.
package utrx_pkg;

    localparam int COORD_BITS = 32;
    localparam int GENE_DEPTH = 1024;
    localparam int GENE_AW    = $clog2(GENE_DEPTH);
    localparam int SLOT_W     = 10;
    localparam int PAR_DEPTH  = 16;
    localparam int PAR_AW     = $clog2(PAR_DEPTH);
    localparam int PAR_CW     = $clog2(PAR_DEPTH + 1);
    localparam int SCAN_CW    = $clog2(GENE_DEPTH + 1);

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_LOAD  = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;

    localparam logic [1:0] KIND_FIVE  = 2'd0;
    localparam logic [1:0] KIND_THREE = 2'd1;
    localparam logic [1:0] KIND_NONE  = 2'd2;
    localparam logic [1:0] KIND_ACK   = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_MISMATCH = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    typedef logic [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        logic   valid;
        logic   sense;
        coord_t fin;
        coord_t beg;
    } gene_t;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              sense;
        coord_t            fin;
        coord_t            beg;
    } parent_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [1:0]        status;
        logic [31:0]       utr_start;
        logic [31:0]       utr_end;
        logic [SLOT_W-1:0] parent_slot;
        logic              parent_sense;
    } result_t;

endpackage

### rtl/utrx_req_if.sv
// Request channel interface: valid/ready plus the request fields.
// Depends on nothing but plain logic types.
interface utrx_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [9:0]  slot;
    logic [31:0] start_pos;
    logic [31:0] end_pos;
    logic        sense;

    modport source (output valid, cmd, slot, start_pos, end_pos, sense, input ready);
    modport sink   (input valid, cmd, slot, start_pos, end_pos, sense, output ready);
endinterface

### rtl/utrx_rsp_if.sv
// Result channel interface: valid/ready plus the result fields.
// Depends on nothing but plain logic types.
interface utrx_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [1:0]  status;
    logic [31:0] utr_start;
    logic [31:0] utr_end;
    logic [9:0]  parent_slot;
    logic        parent_sense;
    logic        last;

    modport source (output valid, kind, status, utr_start, utr_end, parent_slot,
                    parent_sense, last, input ready);
    modport sink   (input valid, kind, status, utr_start, utr_end, parent_slot,
                    parent_sense, last, output ready);
endinterface

### rtl/utr_extension_from_gene_overlap.sv
// Top level of the gene-overlap UTR extension block.
// Depends on utrx_pkg, utrx_req_if and utrx_rsp_if.
//
// The gene table lives in one 1024-entry synchronous memory (start, end, strand,
// valid), the current parents in a 16-entry synchronous memory. After reset the
// block runs a clearing pass over the gene table and takes no request until it
// is done. Per request: a clear sweeps the table; a load is a read-modify-write
// of one entry; a query scans the whole table, then for each of P parents reads
// that parent and compares it against every other parent, reading one per cycle
// through the parent memory read port. Any request can stall on the result
// side. One result register holds the last result back until the next is
// known, so the final result can carry its last flag and overflow status; the
// output register lets a new request be taken while the previous answer still
// waits.
module utr_extension_from_gene_overlap (
    input  logic         clk,
    input  logic         rst_n,
    utrx_req_if.sink     req,
    utrx_rsp_if.source   rsp
);
    import utrx_pkg::*;

    localparam logic [3:0] S_INIT  = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_CLR   = 4'd2;
    localparam logic [3:0] S_LDRD  = 4'd3;
    localparam logic [3:0] S_LDWR  = 4'd4;
    localparam logic [3:0] S_ACK   = 4'd5;
    localparam logic [3:0] S_SCAN  = 4'd6;
    localparam logic [3:0] S_PRD   = 4'd7;
    localparam logic [3:0] S_PLAT  = 4'd8;
    localparam logic [3:0] S_PJ    = 4'd9;
    localparam logic [3:0] S_EMS   = 4'd10;
    localparam logic [3:0] S_EME   = 4'd11;
    localparam logic [3:0] S_FIN   = 4'd12;

    // gene table and parent list memories
    gene_t   gene_mem [GENE_DEPTH];
    parent_t par_mem  [PAR_DEPTH];

    logic [3:0]          state_reg, state_next;
    logic [SCAN_CW-1:0]  cnt_reg, cnt_next;
    logic [SLOT_W-1:0]   slot_reg;
    coord_t              s_reg, e_reg;
    logic                sn_reg;
    logic [1:0]          st_reg, st_next;

    logic                gm_we;
    logic [GENE_AW-1:0]  gm_waddr, gm_raddr;
    gene_t               gm_wdata, gm_q;

    logic                pm_we;
    logic [PAR_AW-1:0]   pm_waddr, pm_raddr;
    parent_t             pm_wdata, pm_q;

    logic [PAR_CW-1:0]   pcnt_reg, pcnt_next;
    logic                over_reg, over_next;
    logic [PAR_AW-1:0]   i_reg, i_next, j_reg, j_next;
    parent_t             cur_reg, cur_next;
    logic                oks_reg, oks_next, oke_reg, oke_next;

    result_t             pend_reg, pend_next;
    logic                pend_v_reg, pend_v_next;
    result_t             out_reg, out_next;
    logic                out_last_reg, out_last_next;
    logic                out_v_reg, out_v_next;
    logic                out_free;

    logic                touch;
    logic                o_hold_s, o_hold_e;
    result_t             new_res;
    logic                emit_ok;
    logic [PAR_AW-1:0]   last_par;

    assign out_free  = !out_v_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign last_par  = PAR_AW'(pcnt_reg - PAR_CW'(1));

    assign rsp.valid        = out_v_reg;
    assign rsp.kind         = out_reg.kind;
    assign rsp.status       = out_reg.status;
    assign rsp.utr_start    = out_reg.utr_start;
    assign rsp.utr_end      = out_reg.utr_end;
    assign rsp.parent_slot  = out_reg.parent_slot;
    assign rsp.parent_sense = out_reg.parent_sense;
    assign rsp.last         = out_last_reg;

    // memories: one write, one registered read each
    always_ff @(posedge clk)
    begin
        if (gm_we)
        begin
            gene_mem[gm_waddr] <= gm_wdata;
        end
        gm_q <= gene_mem[gm_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (pm_we)
        begin
            par_mem[pm_waddr] <= pm_wdata;
        end
        pm_q <= par_mem[pm_raddr];
    end

    // overlap test of the scanned entry; a contig strictly inside a gene misses
    always_comb
    begin
        touch = !((s_reg < gm_q.beg && e_reg < gm_q.beg) ||
                  (s_reg > gm_q.fin && e_reg > gm_q.fin) ||
                  (s_reg > gm_q.beg && e_reg < gm_q.fin));
        o_hold_s = (s_reg >= pm_q.beg) && (s_reg <= pm_q.fin);
        o_hold_e = (e_reg >= pm_q.beg) && (e_reg <= pm_q.fin);
    end

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        st_next       = st_reg;
        pcnt_next     = pcnt_reg;
        over_next     = over_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        cur_next      = cur_reg;
        oks_next      = oks_reg;
        oke_next      = oke_reg;
        pend_next     = pend_reg;
        pend_v_next   = pend_v_reg;
        out_next      = out_reg;
        out_last_next = out_last_reg;
        out_v_next    = out_v_reg && !rsp.ready;
        gm_we         = 1'b0;
        gm_waddr      = cnt_reg[GENE_AW-1:0];
        gm_wdata      = '0;
        gm_raddr      = (state_reg == S_SCAN) ? cnt_reg[GENE_AW-1:0] : GENE_AW'(slot_reg);
        pm_we         = 1'b0;
        pm_waddr      = pcnt_reg[PAR_AW-1:0];
        pm_wdata      = '{slot: SLOT_W'(cnt_reg - SCAN_CW'(1)), sense: gm_q.sense,
                          fin: gm_q.fin, beg: gm_q.beg};
        pm_raddr      = j_reg;
        new_res       = '0;
        emit_ok       = 1'b0;

        unique case (state_reg) inside
            S_INIT, S_CLR:
            begin
                // sweep the table, dropping every valid bit
                gm_we    = 1'b1;
                cnt_next = cnt_reg + SCAN_CW'(1);
                if (cnt_reg == SCAN_CW'(GENE_DEPTH - 1))
                begin
                    cnt_next   = '0;
                    state_next = (state_reg == S_INIT) ? S_IDLE : S_ACK;
                end
            end
            S_IDLE:
            begin
                st_next = ST_OK;
                if (req.valid)
                begin
                    cnt_next = '0;
                    unique case (req.cmd)
                        CMD_CLEAR: state_next = S_CLR;
                        CMD_LOAD:  state_next = S_LDRD;
                        CMD_QUERY:
                        begin
                            state_next = S_SCAN;
                            pcnt_next  = '0;
                            over_next  = 1'b0;
                        end
                        default:   state_next = S_ACK;
                    endcase
                end
            end
            S_LDRD:
            begin
                state_next = S_LDWR;
            end
            S_LDWR:
            begin
                gm_waddr = GENE_AW'(slot_reg);
                if (({1'b0, slot_reg}) < (SLOT_W + 1)'(GENE_DEPTH))
                begin
                    if (!gm_q.valid)
                    begin
                        gm_we    = 1'b1;
                        gm_wdata = '{valid: 1'b1, sense: sn_reg, fin: e_reg, beg: s_reg};
                    end
                    else if (gm_q.sense != sn_reg)
                    begin
                        st_next = ST_MISMATCH;
                    end
                    else
                    begin
                        gm_we    = 1'b1;
                        gm_wdata = gm_q;
                        if (s_reg < gm_q.beg)
                        begin
                            gm_wdata.beg = s_reg;
                        end
                        if (e_reg > gm_q.fin)
                        begin
                            gm_wdata.fin = e_reg;
                        end
                    end
                end
                state_next = S_ACK;
            end
            S_ACK:
            begin
                if (out_free)
                begin
                    out_next      = '{kind: KIND_ACK, status: st_reg, default: '0};
                    out_last_next = 1'b1;
                    out_v_next    = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_SCAN:
            begin
                // read entry cnt, judge entry cnt-1 from the registered data
                cnt_next = cnt_reg + SCAN_CW'(1);
                if (cnt_reg != '0 && gm_q.valid && touch)
                begin
                    if (pcnt_reg < PAR_CW'(PAR_DEPTH))
                    begin
                        pm_we     = 1'b1;
                        pcnt_next = pcnt_reg + PAR_CW'(1);
                    end
                    else
                    begin
                        over_next = 1'b1;
                    end
                end
                if (cnt_reg == SCAN_CW'(GENE_DEPTH))
                begin
                    i_next     = '0;
                    state_next = (pcnt_next == '0) ? S_FIN : S_PRD;
                end
            end
            S_PRD:
            begin
                pm_raddr   = i_reg;
                state_next = S_PLAT;
            end
            S_PLAT:
            begin
                cur_next   = pm_q;
                oks_next   = !((s_reg >= pm_q.beg) && (s_reg <= pm_q.fin));
                oke_next   = !((e_reg >= pm_q.beg) && (e_reg <= pm_q.fin));
                pm_raddr   = '0;
                j_next     = '0;
                state_next = S_PJ;
            end
            S_PJ:
            begin
                // pm_q holds parent j; issue j+1
                if (j_reg != i_reg)
                begin
                    if (o_hold_s || pm_q.beg < cur_reg.beg)
                    begin
                        oks_next = 1'b0;
                    end
                    if (o_hold_e || pm_q.fin > cur_reg.fin)
                    begin
                        oke_next = 1'b0;
                    end
                end
                j_next   = j_reg + PAR_AW'(1);
                pm_raddr = j_reg + PAR_AW'(1);
                if (j_reg == last_par)
                begin
                    state_next = S_EMS;
                end
            end
            S_EMS, S_EME:
            begin
                if (state_reg == S_EMS)
                begin
                    emit_ok = oks_reg;
                    new_res = '{kind: cur_reg.sense ? KIND_FIVE : KIND_THREE, status: ST_OK,
                                utr_start: 32'(s_reg),
                                utr_end: 32'(cur_reg.beg - coord_t'(1)),
                                parent_slot: cur_reg.slot, parent_sense: cur_reg.sense};
                end
                else
                begin
                    emit_ok = oke_reg;
                    new_res = '{kind: cur_reg.sense ? KIND_THREE : KIND_FIVE, status: ST_OK,
                                utr_start: 32'(cur_reg.fin + coord_t'(1)),
                                utr_end: 32'(e_reg),
                                parent_slot: cur_reg.slot, parent_sense: cur_reg.sense};
                end
                if (!emit_ok || !pend_v_reg || out_free)
                begin
                    if (emit_ok)
                    begin
                        // push the held result out, hold the new one
                        if (pend_v_reg)
                        begin
                            out_next      = pend_reg;
                            out_last_next = 1'b0;
                            out_v_next    = 1'b1;
                        end
                        pend_next   = new_res;
                        pend_v_next = 1'b1;
                    end
                    if (state_reg == S_EMS)
                    begin
                        state_next = S_EME;
                    end
                    else
                    begin
                        i_next     = i_reg + PAR_AW'(1);
                        state_next = (i_reg == last_par) ? S_FIN : S_PRD;
                    end
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    if (pend_v_reg)
                    begin
                        out_next = pend_reg;
                    end
                    else
                    begin
                        out_next = '{kind: KIND_NONE, status: ST_OK, default: '0};
                    end
                    out_next.status = over_reg ? ST_OVERFLOW : ST_OK;
                    out_last_next   = 1'b1;
                    out_v_next      = 1'b1;
                    pend_v_next     = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_INIT;
            cnt_reg    <= '0;
            pcnt_reg   <= '0;
            over_reg   <= 1'b0;
            pend_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
            st_reg     <= ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            pcnt_reg   <= pcnt_next;
            over_reg   <= over_next;
            pend_v_reg <= pend_v_next;
            out_v_reg  <= out_v_next;
            st_reg     <= st_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            slot_reg <= req.slot;
            s_reg    <= coord_t'(req.start_pos);
            e_reg    <= coord_t'(req.end_pos);
            sn_reg   <= req.sense;
        end
        i_reg        <= i_next;
        j_reg        <= j_next;
        cur_reg      <= cur_next;
        oks_reg      <= oks_next;
        oke_reg      <= oke_next;
        pend_reg     <= pend_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
    end

`ifndef SYNTHESIS
    a_pcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pcnt_reg <= PAR_CW'(PAR_DEPTH))
        else $error("parent count above capacity");
    a_over_full: assert property (@(posedge clk) disable iff (!rst_n)
        over_reg |-> pcnt_reg == PAR_CW'(PAR_DEPTH))
        else $error("overflow without a full parent list");
    a_no_pend_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |-> !pend_v_reg)
        else $error("held result left over at new request");
    a_query_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && req.cmd == CMD_QUERY) |=> state_reg == S_SCAN)
        else $error("query did not start the table scan");
`endif

endmodule
